/* rtl/core/stkmd_pkg.sv */
// ----------------------------------------------------------------------------
// stkmd_pkg
// Shared types and codes for the stack with middle delete: the word type,
// the operation and status codes, and the per-cycle control of a stack cell.
// ----------------------------------------------------------------------------
package stkmd_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    // Operation codes of a request.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_MID  = 2'd2;
    localparam logic [1:0] OP_PEEK = 2'd3;

    // Status codes of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Word returned when the stack is empty.
    localparam word_t EMPTY_WORD = '1;

    // Control broadcast to every cell of the chain in one cycle.
    typedef struct packed {
        logic push;      // shift toward the bottom, new word enters at the top
        logic pop;       // shift toward the top
        logic del;       // cells at or below the removed place shift toward the top
        logic load_rd;   // copy each stored word into the read-out chain
        logic shift_rd;  // move the read-out chain one cell toward the top
    } cell_ctrl_t;

endpackage

/* rtl/core/stkmd_cell.sv */
// ----------------------------------------------------------------------------
// stkmd_cell
// One place of the stack. Cell 0 holds the top word. Each cell takes its
// next word from its upper or lower neighbor and keeps one stage of the
// read-out chain that carries a removed word up to cell 0.
// ----------------------------------------------------------------------------
module stkmd_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                      clk,
    input  stkmd_pkg::cell_ctrl_t     ctrl,
    input  logic [$clog2(DEPTH)-1:0]  del_pos,
    input  stkmd_pkg::word_t          up_data,
    input  stkmd_pkg::word_t          dn_data,
    input  stkmd_pkg::word_t          dn_rd,
    output stkmd_pkg::word_t          data,
    output stkmd_pkg::word_t          rd
);
    import stkmd_pkg::*;

    localparam int IW = $clog2(DEPTH);

    word_t data_reg;
    word_t data_next;
    word_t rd_reg;
    word_t rd_next;
    logic  at_or_below;

    // This cell lies at or below the removed place (counted from the top).
    assign at_or_below = IW'(IDX) >= del_pos;

    // Stored word: take from a neighbor according to the operation.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = up_data;
        end
        else if (ctrl.pop || (ctrl.del && at_or_below))
        begin
            data_next = dn_data;
        end
    end

    // Read-out chain: load the stored word, then move toward the top.
    always_comb
    begin
        rd_next = rd_reg;
        if (ctrl.load_rd)
        begin
            rd_next = data_reg;
        end
        else if (ctrl.shift_rd)
        begin
            rd_next = dn_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule

/* rtl/core/stack_with_middle_delete_core.sv */
// ----------------------------------------------------------------------------
// stack_with_middle_delete_core
// Bounded LIFO stack of signed words built as a chain of cells with the top
// at cell 0. Push, pop, peek and remove-middle, one result beat per request.
// ----------------------------------------------------------------------------
// Push, pop and peek: result in the cycle after the request, one request a cycle while busy is low.
// Remove-middle: the removed word climbs the read-out chain one cell a cycle
//   from place t = ceil((count-1)/2) up to cell 0, and then the result comes;
//   busy stays high meanwhile. Empty or t = 0 is answered like a pop.
// Reset clears the fill count and the sequencer; stored words are undefined
// until pushed. The receiver cannot stall: done is high for exactly one cycle.
module stack_with_middle_delete_core #(
    parameter int DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              op,
    input  stkmd_pkg::word_t        push_value,
    output logic                    done,
    output stkmd_pkg::word_t        read_value,
    output logic [1:0]              status,
    output logic [4:0]              fill_count
);
    import stkmd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] remain_reg;
    logic [IW-1:0] remain_next;
    logic          done_reg;
    logic          done_next;
    word_t         value_reg;
    word_t         value_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;

    cell_ctrl_t    ctrl;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] mid_off;
    logic [IW-1:0] del_pos;

    word_t         data_w [DEPTH];
    word_t         rd_w   [DEPTH];

    assign busy     = (state_reg == S_DRAIN);
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Place of the middle entry counted from the top: count-1-(count-1)/2.
    assign cnt_m1  = count_reg - CW'(1);
    assign mid_off = cnt_m1 - (cnt_m1 >> 1);
    assign del_pos = mid_off[IW-1:0];

    // Chain of cells; cell 0 is the top of the stack.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t up_d;
        word_t dn_d;
        word_t dn_r;

        if (i == 0)
        begin : g_top
            assign up_d = push_value;
        end
        else
        begin : g_mid
            assign up_d = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign dn_d = data_w[i];
            assign dn_r = rd_w[i];
        end
        else
        begin : g_low
            assign dn_d = data_w[i+1];
            assign dn_r = rd_w[i+1];
        end

        stkmd_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .del_pos (del_pos),
            .up_data (up_d),
            .dn_data (dn_d),
            .dn_rd   (dn_r),
            .data    (data_w[i]),
            .rd      (rd_w[i])
        );
    end

    // Request decode and read-out sequencing.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        status_next = status_reg;
        ctrl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    value_next  = '0;
                    status_next = ST_OK;
                    if (op == OP_PUSH)
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.push  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                        value_next  = EMPTY_WORD;
                    end
                    else
                    begin
                        case (op)
                            OP_POP:
                            begin
                                value_next = data_w[0];
                                ctrl.pop   = 1'b1;
                                count_next = cnt_m1;
                            end
                            OP_PEEK:
                            begin
                                value_next = data_w[0];
                            end
                            OP_MID:
                            begin
                                ctrl.del     = 1'b1;
                                ctrl.load_rd = 1'b1;
                                count_next   = cnt_m1;
                                if (del_pos == '0)
                                begin
                                    value_next = data_w[0];
                                end
                                else
                                begin
                                    done_next   = 1'b0;
                                    remain_next = del_pos;
                                    state_next  = S_DRAIN;
                                end
                            end
                            default:
                            begin
                                value_next = '0;
                            end
                        endcase
                    end
                end
            end
            S_DRAIN:
            begin
                if (remain_reg != '0)
                begin
                    ctrl.shift_rd = 1'b1;
                    remain_next   = remain_reg - IW'(1);
                end
                else
                begin
                    value_next = rd_w[0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            done_reg   <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign read_value = value_reg;
    assign status     = status_reg;
    assign fill_count = 5'(count_reg);

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above capacity");

    // A result beat follows an accepted request or the end of a read-out.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(state_reg == S_DRAIN)))
        else $error("result beat without a request");

    // An empty report leaves the stack empty.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (count_reg == '0))
        else $error("empty status with entries held");

    // A dropped push is only reported when the stack is full.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status below capacity");

endmodule

/* bench/tb_stack_with_middle_delete_core.sv */
// ----------------------------------------------------------------------------
// tb_stack_with_middle_delete_core
// Self-checking bench for the stack core with remove-middle. A behavioral
// stack tracks every accepted request and queues the result it predicts.
// Each result beat is compared field by field with the oldest prediction.
// The requests are directed corner cases followed by random traffic that
// walks the fill level between empty and full, sent in bursts with gaps.
// ----------------------------------------------------------------------------
module tb_stack_with_middle_delete_core;

    timeunit 1ns;
    timeprecision 1ps;

    import stkmd_pkg::*;

    localparam int STACK_DEPTH = 16;

    // One predicted result beat.
    typedef struct {
        word_t      read_value;
        logic [1:0] status;
        logic [4:0] fill_count;
    } stack_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    word_t      push_value;
    logic       done;
    word_t      read_value;
    logic [1:0] status;
    logic [4:0] fill_count;

    // Behavioral copy of the stack, index 0 is the bottom.
    word_t         stack_words [STACK_DEPTH];
    int unsigned   stack_held = 0;
    stack_result_t pending_results [$];

    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int full_pushes     = 0;
    int empty_reads     = 0;
    int middle_removes  = 0;
    int peak_fill       = 0;

    // Sender pacing state.
    int burst_left  = 1;
    bit steady_flow = 1'b0;

    stack_with_middle_delete_core #(
        .DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .push_value (push_value),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .fill_count (fill_count)
    );

    always #1 clk = ~clk;

    // Apply one request to the behavioral stack and return its result.
    function automatic stack_result_t predict_request(input logic [1:0] req_op,
                                                      input word_t word);
        stack_result_t res;
        int unsigned   mid;
        res.read_value = '0;
        res.status     = ST_OK;
        if (req_op == OP_PUSH) begin
            if (stack_held >= STACK_DEPTH) begin
                res.status = ST_FULL;
                full_pushes++;
            end
            else begin
                stack_words[stack_held] = word;
                stack_held++;
            end
        end
        else if (stack_held == 0) begin
            res.read_value = EMPTY_WORD;
            res.status     = ST_EMPTY;
            empty_reads++;
        end
        else if (req_op == OP_POP) begin
            stack_held--;
            res.read_value = stack_words[stack_held];
        end
        else if (req_op == OP_PEEK) begin
            res.read_value = stack_words[stack_held - 1];
        end
        else begin
            // Remove the middle entry and close the hole from above.
            mid = (stack_held - 1) / 2;
            res.read_value = stack_words[mid];
            for (int unsigned i = mid; i + 1 < stack_held; i++)
                stack_words[i] = stack_words[i + 1];
            stack_held--;
            middle_removes++;
        end
        res.fill_count = stack_held[4:0];
        if (stack_held > peak_fill)
            peak_fill = stack_held;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Present one request, hold it until accepted, then pace the next beat.
    task automatic send_request(input logic [1:0] req_op, input word_t word);
        int gap;
        start      <= 1'b1;
        op         <= req_op;
        push_value <= word;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(predict_request(req_op, word));
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_flow ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                // Idle with junk on the request fields.
                start      <= 1'b0;
                op         <= 2'($urandom);
                push_value <= word_t'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Pop, remove-middle and peek on an empty stack.
    task automatic test_empty_stack();
        send_request(OP_POP, 32'h0BAD_F00D);
        send_request(OP_MID, 32'h1234_5678);
        send_request(OP_PEEK, '0);
    endtask

    // Fill the stack with extreme words, then push once more when full.
    task automatic test_fill_to_full();
        word_t fill_words [STACK_DEPTH];
        fill_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000,
                       32'h0000_FFFF, 32'hFF00_FF00, 32'h00FF_00FF, 32'hF0F0_F0F0,
                       32'h0F0F_0F0F, 32'hCCCC_CCCC, 32'h3333_3333, 32'hFFFF_FFFE};
        foreach (fill_words[i])
            send_request(OP_PUSH, fill_words[i]);
        send_request(OP_PUSH, 32'h1234_5678);
    endtask

    // Peek, two remove-middles and a pop on a full stack, the longest middle shifts.
    task automatic test_peek_and_middle();
        send_request(OP_PEEK, '0);
        send_request(OP_MID, '0);
        send_request(OP_MID, '0);
        send_request(OP_POP, '0);
    endtask

    // Random traffic in segments, each with its own mix of operations.
    task automatic test_random_traffic(input int beats);
        int    push_pct;
        int    mid_pct;
        int    roll;
        int    seg_len;
        word_t word;
        logic [1:0] req_op;
        while (beats > 0) begin
            case ($urandom_range(0, 3))
                0: push_pct = 15;
                1: push_pct = 50;
                2: push_pct = 85;
                default: push_pct = 60;
            endcase
            mid_pct     = $urandom_range(10, 60);
            steady_flow = ($urandom_range(0, 3) == 0);
            seg_len     = $urandom_range(20, 60);
            for (int k = 0; k < seg_len && beats > 0; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    req_op = OP_PUSH;
                else begin
                    roll = $urandom_range(0, 99);
                    if (roll < mid_pct)
                        req_op = OP_MID;
                    else if (roll < mid_pct + (100 - mid_pct) / 2)
                        req_op = OP_POP;
                    else
                        req_op = OP_PEEK;
                end
                case ($urandom_range(0, 11))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'hFFFF_FFFF;
                    3: word = '0;
                    default: word = word_t'($urandom);
                endcase
                send_request(req_op, word);
                beats--;
            end
        end
    endtask

    // Check every result beat against the oldest prediction.
    always @(posedge clk) begin : check_results
        stack_result_t want;
        if (rst_n === 1'b1 && done === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", read_value, '0);
            end
            else begin
                want = pending_results.pop_front();
                results_checked++;
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (fill_count !== want.fill_count)
                    report_mismatch("fill_count", 32'(fill_count), 32'(want.fill_count));
            end
        end
    end

    initial begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        op         <= OP_PUSH;
        push_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_fill_to_full();
        test_peek_and_middle();
        test_random_traffic(1625);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d middle removes",
                 requests_sent, results_checked, middle_removes);
        $display("full pushes %0d, empty reads %0d, peak fill %0d, mismatches %0d",
                 full_pushes, empty_reads, peak_fill, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #500us;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
